### rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define GTCF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked on every rising clock edge outside reset
`define GTCF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/gtcf_pkg.sv
// package: types, constants and helpers of the coordinate fold
`default_nettype none
package gtcf_pkg;
  localparam int COORD_W = 16;
  localparam int REM_W   = 17;
  localparam int SIDE_W  = 13;
  localparam int NSTEP   = REM_W;

  typedef enum logic [3:0] {
    TOPO_TORUS     = 4'd0,
    TOPO_CYL_X     = 4'd1,
    TOPO_CYL_Y     = 4'd2,
    TOPO_PLANE     = 4'd3,
    TOPO_SPHERE_L  = 4'd4,
    TOPO_SPHERE_R  = 4'd5,
    TOPO_CONE_LT   = 4'd6,
    TOPO_CONE_RT   = 4'd7,
    TOPO_CONE_LB   = 4'd8,
    TOPO_CONE_RB   = 4'd9
  } topo_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic [2:0] TURN_QUARTER  = 3'd2;
  localparam logic [2:0] TURN_HALF     = 3'd4;
  localparam logic [2:0] TURN_3QUARTER = 3'd6;

  // one item moving down the row of divide cells
  typedef struct packed {
    logic                       valid;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [2:0]                 dir;
    logic [REM_W-1:0]           rx;
    logic [REM_W-1:0]           ry;
  } stage_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [2:0]                dir;
    logic                      on_grid;
  } result_t;

  // nonzero direction turns, zero passes through
  function automatic logic [2:0] turn(input logic [2:0] d, input logic [2:0] k);
    turn = (d != 3'd0) ? (d + k) : 3'd0;
  endfunction
endpackage
`default_nettype wire

### rtl/core/gtcf_if.sv
// valid/ready channel interfaces for coordinates, results and config
`default_nettype none
interface gtcf_coord_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic [2:0]        direction;
  modport source (output valid, coord_x, coord_y, direction, input ready);
  modport sink   (input valid, coord_x, coord_y, direction, output ready);
endinterface

interface gtcf_result_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] safe_x;
  logic signed [15:0] safe_y;
  logic [2:0]        safe_direction;
  logic              on_grid;
  modport source (output valid, safe_x, safe_y, safe_direction, on_grid, input ready);
  modport sink   (input valid, safe_x, safe_y, safe_direction, on_grid, output ready);
endinterface

interface gtcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/gtcf_cell.sv
// one restoring remainder step for both axes
`default_nettype none
module gtcf_cell import gtcf_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [REM_W-1:0] mx,
  input  wire logic [REM_W-1:0] my,
  input  wire stage_t           din,
  output stage_t                dout
);
  localparam int WIDE = 2 * REM_W;

  logic [WIDE-1:0] dx, dy;
  stage_t          nxt;

  // subtract the shifted modulus where it fits
  always_comb begin
    dx  = {{REM_W{1'b0}}, mx} << SHIFT;
    dy  = {{REM_W{1'b0}}, my} << SHIFT;
    nxt = din;
    if ({{REM_W{1'b0}}, din.rx} >= dx) nxt.rx = din.rx - dx[REM_W-1:0];
    if ({{REM_W{1'b0}}, din.ry} >= dy) nxt.ry = din.ry - dy[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/gtcf_fold.sv
// floored-modulo fixup and quadrant fold for the selected topology
`default_nettype none
module gtcf_fold import gtcf_pkg::*; (
  input  wire logic [3:0]       mode,
  input  wire logic [REM_W-1:0] sw,
  input  wire logic [REM_W-1:0] sh,
  input  wire logic [REM_W-1:0] mx,
  input  wire logic [REM_W-1:0] my,
  input  wire stage_t           st,
  output result_t               res
);
  logic signed [18:0] x, y, s, h, fx, fy, ox, oy, s2;
  logic [2:0]         d;
  logic               ok;

  // sphere uses wrapped values, cone uses raw values
  function automatic logic signed [18:0] fx_sel(input logic [3:0] m,
      input logic signed [18:0] w, input logic signed [18:0] r);
    fx_sel = (m == TOPO_SPHERE_L) ? w : r;
  endfunction

  function automatic logic signed [18:0] fy_sel(input logic [3:0] m,
      input logic signed [18:0] w, input logic signed [18:0] r);
    fy_sel = (m == TOPO_SPHERE_L) ? w : r;
  endfunction

  always_comb begin
    x  = 19'(st.x);
    y  = 19'(st.y);
    s  = {2'b00, sw};
    h  = {2'b00, sh};
    s2 = s + s;
    // negative input with nonzero remainder folds to modulus minus remainder
    fx = (st.x < 0 && st.rx != '0) ? {2'b00, mx - st.rx} : {2'b00, st.rx};
    fy = (st.y < 0 && st.ry != '0) ? {2'b00, my - st.ry} : {2'b00, st.ry};
    ox = x;
    oy = y;
    d  = st.dir;
    ok = 1'b0;
    case (mode)
      TOPO_TORUS: begin
        ox = fx; oy = fy; ok = 1'b1;
      end
      TOPO_CYL_X: begin
        ox = fx; ok = (y >= 0) && (y < h);
      end
      TOPO_CYL_Y: begin
        oy = fy; ok = (x >= 0) && (x < s);
      end
      TOPO_PLANE: begin
        ok = (x >= 0) && (x < s) && (y >= 0) && (y < h);
      end
      TOPO_SPHERE_L, TOPO_CONE_RB: begin
        if (mode == TOPO_SPHERE_L) begin
          ox = fx; oy = fy; ok = 1'b1;
        end else begin
          ok = (x >= 0) && (x < s2) && (y >= 0) && (y < s2);
        end
        if (mode == TOPO_SPHERE_L || ok) begin
          if (ox < s) begin
            if (oy >= s) begin
              ox = s2 - oy - 1; oy = fx_sel(mode, fx, x); d = turn(st.dir, TURN_3QUARTER);
            end
          end else if (oy < s) begin
            oy = s2 - ox - 1; ox = fy_sel(mode, fy, y); d = turn(st.dir, TURN_QUARTER);
          end else begin
            ox = s2 - ox - 1; oy = s2 - oy - 1; d = turn(st.dir, TURN_HALF);
          end
        end
      end
      TOPO_SPHERE_R: begin
        ok = 1'b1;
        if (fx < s) begin
          if (fy >= s) begin
            ox = fy - s; oy = s - fx - 1; d = turn(st.dir, TURN_QUARTER);
          end else begin
            ox = fx; oy = fy;
          end
        end else if (fy < s) begin
          ox = s - fy - 1; oy = fx - s; d = turn(st.dir, TURN_3QUARTER);
        end else begin
          ox = s2 - fx - 1; oy = s2 - fy - 1; d = turn(st.dir, TURN_HALF);
        end
      end
      TOPO_CONE_LT: begin
        if (x >= -s && x < s && y >= -s && y < s) begin
          ok = 1'b1;
          if (x < 0) begin
            if (y < 0) begin
              ox = -x - 1; oy = -y - 1; d = turn(st.dir, TURN_HALF);
            end else begin
              ox = y; oy = -x - 1; d = turn(st.dir, TURN_QUARTER);
            end
          end else if (y < 0) begin
            ox = -y - 1; oy = x; d = turn(st.dir, TURN_3QUARTER);
          end
        end
      end
      TOPO_CONE_RT: begin
        if (x >= 0 && x < s2 && y >= -s && y < s) begin
          ok = 1'b1;
          if (x >= s) begin
            if (y < 0) begin
              ox = s2 - x - 1; oy = -y - 1; d = turn(st.dir, TURN_HALF);
            end else begin
              ox = s - y - 1; oy = x - s; d = turn(st.dir, TURN_3QUARTER);
            end
          end else if (y < 0) begin
            ox = y + s; oy = s - x - 1; d = turn(st.dir, TURN_QUARTER);
          end
        end
      end
      TOPO_CONE_LB: begin
        if (x >= -s && x < s && y >= 0 && y < s2) begin
          ok = 1'b1;
          if (x < 0) begin
            if (y >= s) begin
              ox = -x - 1; oy = s2 - y - 1; d = turn(st.dir, TURN_HALF);
            end else begin
              ox = s - y - 1; oy = x + s; d = turn(st.dir, TURN_3QUARTER);
            end
          end else if (y >= s) begin
            ox = y - s; oy = s - x - 1; d = turn(st.dir, TURN_QUARTER);
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    res.x       = ox[15:0];
    res.y       = oy[15:0];
    res.dir     = d;
    res.on_grid = ok;
  end
endmodule
`default_nettype wire

### rtl/core/grid_topology_coordinate_fold.sv
// a coordinate transaction passes the 17-cell remainder row, then the result register
// throughput: one transaction per cycle while the result channel is not stalled;
// a stalled result register holds the whole row in place
// reset (rst, synchronous): clears all stage valids, mode torus, sides 64
`default_nettype none
module grid_topology_coordinate_fold import gtcf_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input wire logic        clk,
  input wire logic        rst,
  gtcf_coord_if.sink      coord,
  gtcf_result_if.source   result,
  gtcf_cfg_if.sink        cfg
);
  `include "assert_macros.svh"

  localparam logic [REM_W-1:0] MAX_S = REM_W'(MAX_SIDE);

  logic [3:0]        mode;
  logic [SIDE_W-1:0] width_reg, height_reg;
  logic [REM_W-1:0]  sw, sh, mx, my;
  logic              advance;
  stage_t            st [0:NSTEP];
  result_t           res;
  logic [REM_W-1:0]  ax, ay;

  // config registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= TOPO_TORUS;
      width_reg  <= SIDE_W'(64);
      height_reg <= SIDE_W'(64);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_MODE:   mode       <= cfg.data[3:0];
        REG_WIDTH:  width_reg  <= cfg.data;
        REG_HEIGHT: height_reg <= cfg.data;
        default:    mode       <= mode;
      endcase
    end
  end

  // clamped sides and moduli per axis
  always_comb begin
    sw = {{(REM_W-SIDE_W){1'b0}}, width_reg};
    sh = {{(REM_W-SIDE_W){1'b0}}, height_reg};
    if (sw == '0) sw = REM_W'(1);
    if (sw > MAX_S) sw = MAX_S;
    if (sh == '0) sh = REM_W'(1);
    if (sh > MAX_S) sh = MAX_S;
    if (mode == TOPO_SPHERE_L || mode == TOPO_SPHERE_R) begin
      mx = sw << 1;
      my = sw << 1;
    end else begin
      mx = sw;
      my = sh;
    end
  end

  // head of the row: magnitudes of the coordinates
  assign advance     = !result.valid || result.ready;
  assign coord.ready = advance;
  assign ax = coord.coord_x[15] ? (REM_W'(0) - REM_W'(coord.coord_x))
                                : REM_W'(coord.coord_x);
  assign ay = coord.coord_y[15] ? (REM_W'(0) - REM_W'(coord.coord_y))
                                : REM_W'(coord.coord_y);
  always_comb begin
    st[0].valid = coord.valid;
    st[0].x     = coord.coord_x;
    st[0].y     = coord.coord_y;
    st[0].dir   = coord.direction;
    st[0].rx    = ax;
    st[0].ry    = ay;
  end

  // row of remainder cells, widest shift first
  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    gtcf_cell #(.SHIFT(NSTEP - 1 - i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .mx      (mx),
      .my      (my),
      .din     (st[i]),
      .dout    (st[i+1])
    );
  end

  gtcf_fold u_fold (
    .mode (mode),
    .sw   (sw),
    .sh   (sh),
    .mx   (mx),
    .my   (my),
    .st   (st[NSTEP]),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= st[NSTEP].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      result.safe_x         <= res.x;
      result.safe_y         <= res.y;
      result.safe_direction <= res.dir;
      result.on_grid        <= res.on_grid;
    end
  end

  `GTCF_ASSERT_NXT(a_enter_row, clk, rst, coord.valid && coord.ready, st[1].valid)
  `GTCF_ASSERT_NXT(a_row_holds, clk, rst, !advance, $stable(st[NSTEP].valid))
  `GTCF_ASSERT_NXT(a_row_to_out, clk, rst, advance && st[NSTEP].valid, result.valid)
endmodule
`default_nettype wire
